/* sv/utc_timestamp_text_to_epoch_macros.svh */
// assertion macros used by the checker of this block
`ifndef UTC_TIMESTAMP_TEXT_TO_EPOCH_MACROS_SVH
`define UTC_TIMESTAMP_TEXT_TO_EPOCH_MACROS_SVH

// same-cycle implication, quiet while in reset
`define UTTE_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("utte assertion failed");

// next-cycle implication, quiet while in reset
`define UTTE_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("utte assertion failed");

// next-cycle implication that also holds across reset
`define UTTE_ASSERT_NXT_NR(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("utte assertion failed");

`endif

/* sv/utte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utte_pkg;

  localparam int QUEUE_DEPTH = 2;

  // position in the text
  localparam logic [4:0] PH_DASH1     = 5'd4;
  localparam logic [4:0] PH_DASH2     = 5'd7;
  localparam logic [4:0] PH_TEE       = 5'd10;
  localparam logic [4:0] PH_COLON1    = 5'd13;
  localparam logic [4:0] PH_COLON2    = 5'd16;
  localparam logic [4:0] PH_AFTER_SEC = 5'd19;
  localparam logic [4:0] PH_FRAC_ONE  = 5'd20;
  localparam logic [4:0] PH_FRAC_MORE = 5'd21;
  localparam logic [4:0] PH_DONE      = 5'd22;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;

  // one parsed timestamp handed from the parser to the epoch unit
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

endpackage

`default_nettype wire

/* sv/utte_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module utte_queue #(
  parameter int DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  utte_pkg::rec_t   push_rec,
  output logic             full,
  input  wire              pop,
  output logic             empty,
  output utte_pkg::rec_t   head
);
  import utte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/utte_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module utte_front (
  input  wire              clk,
  input  wire              rst,
  input  wire  [7:0]       text_byte,
  input  wire              is_last,
  input  wire              take,
  output logic             push,
  output utte_pkg::rec_t   push_rec
);
  import utte_pkg::*;

  logic [4:0]  phase, phase_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic        err, err_next;

  logic       is_digit;
  logic [3:0] dval;
  logic       is_z;

  assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign dval     = text_byte[3:0];
  assign is_z     = (text_byte == CH_Z_UP) || (text_byte == CH_Z_LO);

  function automatic logic [6:0] shift_in(input logic [6:0] v, input logic [3:0] d);
    shift_in = 7'(v * 7'd10) + 7'(d);
  endfunction

  always_comb begin
    phase_next  = phase;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    err_next    = err;
    if (!err) begin
      case (phase)
        5'd0, 5'd1, 5'd2, 5'd3: begin
          if (is_digit) begin
            year_next  = 14'(year * 14'd10) + 14'(dval);
            phase_next = phase + 5'd1;
          end else begin
            err_next = 1'b1;
          end
        end
        5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15, 5'd17, 5'd18: begin
          if (is_digit) begin
            phase_next = phase + 5'd1;
            case (phase)
              5'd5, 5'd6:   month_next  = shift_in(month, dval);
              5'd8, 5'd9:   day_next    = shift_in(day, dval);
              5'd11, 5'd12: hour_next   = shift_in(hour, dval);
              5'd14, 5'd15: minute_next = shift_in(minute, dval);
              default:      second_next = shift_in(second, dval);
            endcase
          end else begin
            err_next = 1'b1;
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (text_byte == CH_DASH) phase_next = phase + 5'd1;
          else err_next = 1'b1;
        end
        PH_COLON1, PH_COLON2: begin
          if (text_byte == CH_COLON) phase_next = phase + 5'd1;
          else err_next = 1'b1;
        end
        PH_TEE: begin
          if (text_byte == CH_T_UP || text_byte == CH_T_LO) phase_next = phase + 5'd1;
          else err_next = 1'b1;
        end
        PH_AFTER_SEC: begin
          if (text_byte == CH_DOT) phase_next = PH_FRAC_ONE;
          else if (is_z) phase_next = PH_DONE;
          else err_next = 1'b1;
        end
        PH_FRAC_ONE: begin
          if (is_digit) phase_next = PH_FRAC_MORE;
          else err_next = 1'b1;
        end
        PH_FRAC_MORE: begin
          if (is_z) phase_next = PH_DONE;
          else if (!is_digit) err_next = 1'b1;
        end
        default: err_next = 1'b1;
      endcase
    end
  end

  assign push = take && is_last;

  always_comb begin
    push_rec.ok = !err_next && (phase_next == PH_DONE) &&
                  (month_next >= 7'd1) && (month_next <= 7'd12) &&
                  (day_next >= 7'd1) && (day_next <= 7'd31) &&
                  (hour_next <= 7'd23) && (minute_next <= 7'd59) &&
                  (second_next <= 7'd60);
    push_rec.year   = year_next;
    push_rec.month  = month_next;
    push_rec.day    = day_next;
    push_rec.hour   = hour_next;
    push_rec.minute = minute_next;
    push_rec.second = second_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase  <= '0;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      err    <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      err    <= err_next;
    end
  end

endmodule

`default_nettype wire

/* sv/utte_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module utte_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_empty,
  input  utte_pkg::rec_t     q_head,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               parse_ok,
  output logic signed [38:0] epoch_seconds
);
  import utte_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ERA  = 6'b000010,
    ST_YOE  = 6'b000100,
    ST_DOE  = 6'b001000,
    ST_DAYS = 6'b010000,
    ST_SECS = 6'b100000
  } state_t;

  state_t state;

  logic               ok_r;
  logic signed [14:0] y_r;
  logic [8:0]         doy_r;
  logic [6:0]         h_r, m_r, s_r;
  logic signed [5:0]  era_r;
  logic [16:0]        tod_r;
  logic [8:0]         yoe_r;
  logic [17:0]        doe_r;
  logic signed [23:0] days_r;

  logic [26:0]        era_prod;
  logic [18:0]        yoe41;
  logic [16:0]        tod_sum;
  logic signed [38:0] secs;

  // days from march 1 to the first of the month
  function automatic logic [8:0] doy_base(input logic [6:0] mon);
    case (mon)
      7'd1:    doy_base = 9'd306;
      7'd2:    doy_base = 9'd337;
      7'd3:    doy_base = 9'd0;
      7'd4:    doy_base = 9'd31;
      7'd5:    doy_base = 9'd61;
      7'd6:    doy_base = 9'd92;
      7'd7:    doy_base = 9'd122;
      7'd8:    doy_base = 9'd153;
      7'd9:    doy_base = 9'd184;
      7'd10:   doy_base = 9'd214;
      7'd11:   doy_base = 9'd245;
      7'd12:   doy_base = 9'd275;
      default: doy_base = 9'd0;
    endcase
  endfunction

  assign pop = (state == ST_IDLE) && !q_empty;

  // y / 400 by reciprocal, exact for y below 10000
  assign era_prod = 27'(y_r[13:0]) * 27'd5243;
  // yoe / 100 by reciprocal, exact for yoe below 400
  assign yoe41    = 19'(yoe_r) * 19'd41;
  assign tod_sum  = 17'(17'(h_r) * 17'd3600) + 17'(17'(m_r) * 17'd60) + 17'(s_r);
  assign secs     = 39'(days_r) * 39'sd86400 + $signed({22'b0, tod_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_SECS && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (!q_empty) state <= ST_ERA;
        ST_ERA:  state <= ST_YOE;
        ST_YOE:  state <= ST_DOE;
        ST_DOE:  state <= ST_DAYS;
        ST_DAYS: state <= ST_SECS;
        ST_SECS: begin
          if (!out_valid || out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ok_r  <= q_head.ok;
        y_r   <= $signed({1'b0, q_head.year}) - ((q_head.month <= 7'd2) ? 15'sd1 : 15'sd0);
        doy_r <= doy_base(q_head.month) + 9'(q_head.day) - 9'd1;
        h_r   <= q_head.hour;
        m_r   <= q_head.minute;
        s_r   <= q_head.second;
      end
      ST_ERA: begin
        era_r <= y_r[14] ? -6'sd1 : $signed({1'b0, era_prod[25:21]});
        tod_r <= tod_sum;
      end
      ST_YOE:  yoe_r <= 9'(y_r - 15'(era_r) * 15'sd400);
      ST_DOE:  doe_r <= 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(yoe41[18:12]) +
                        18'(doy_r);
      ST_DAYS: days_r <= 24'(era_r) * 24'sd146097 + $signed({6'b0, doe_r}) - 24'sd719468;
      ST_SECS: begin
        if (!out_valid || out_ready) begin
          parse_ok      <= ok_r;
          epoch_seconds <= ok_r ? secs : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/utc_timestamp_text_to_epoch.sv */
// utc timestamp text to unix epoch seconds
//
// input channel (in_valid/in_ready): one text character per transfer in
// text_byte, is_last set on the final character. a byte is taken every
// cycle while the queue between parser and epoch unit has room; while it
// is full, every byte waits.
// output channel (out_valid/out_ready): one transfer per text, parse_ok and
// epoch_seconds (zero when parse_ok is low).
// the final byte pushes its record into the queue; the epoch unit pops it
// in idle and runs era, yoe, doe, days and secs before out_valid rises.
// throughput: the parser takes 1 byte per cycle while the queue has room;
// the epoch unit does one text at a time: pop plus five arithmetic steps.
// a stalled receiver holds the result in the output register; the epoch
// unit waits on it, then the queue fills, then input bytes are held off.
// reset (rst, synchronous) clears the parser, empties the queue and drops
// out_valid; the next byte starts a new text.
`timescale 1ns / 1ps
`default_nettype none

module utc_timestamp_text_to_epoch #(
  parameter int QUEUE_DEPTH = utte_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         text_byte,
  input  wire                is_last,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               parse_ok,
  output logic signed [38:0] epoch_seconds
);
  import utte_pkg::*;

  logic push;
  rec_t push_rec;
  logic q_full;
  logic q_empty;
  logic pop;
  rec_t q_head;

  assign in_ready = !q_full;

  utte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .is_last   (is_last),
    .take      (in_valid && in_ready),
    .push      (push),
    .push_rec  (push_rec)
  );

  utte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  utte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .parse_ok      (parse_ok),
    .epoch_seconds (epoch_seconds)
  );

endmodule

`default_nettype wire

/* sv/utte_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "utc_timestamp_text_to_epoch_macros.svh"

module utte_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire [7:0]         text_byte,
  input wire               is_last,
  input wire               out_valid,
  input wire               out_ready,
  input wire               parse_ok,
  input wire signed [38:0] epoch_seconds
);

  // a held result keeps its value
  `UTTE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(parse_ok) && $stable(epoch_seconds))

  // a failed parse reports zero seconds
  `UTTE_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && !parse_ok, epoch_seconds == 39'sd0)

  // a good parse stays within years 0000 to 9999
  `UTTE_ASSERT_IMP(a_ok_range, clk, rst, out_valid && parse_ok, (epoch_seconds >= -39'sd62167219200) && (epoch_seconds <= 39'sd253402300800))

  // no result straight out of reset
  `UTTE_ASSERT_NXT_NR(a_rst_idle, clk, rst, !out_valid)

  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ is_last ^ (^text_byte);

endmodule

bind utc_timestamp_text_to_epoch utte_checker u_utte_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .text_byte     (text_byte),
  .is_last       (is_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .parse_ok      (parse_ok),
  .epoch_seconds (epoch_seconds)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import utte_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               ok;
    logic signed [38:0] secs;
  } epoch_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         text_byte;
  logic               is_last;
  logic               out_valid;
  logic               out_ready;
  logic               parse_ok;
  logic signed [38:0] epoch_seconds;

  // scanner state mirrored from the block
  logic [4:0]  scan_phase;
  logic [13:0] scan_year;
  logic [6:0]  scan_month;
  logic [6:0]  scan_day;
  logic [6:0]  scan_hour;
  logic [6:0]  scan_minute;
  logic [6:0]  scan_second;
  logic        scan_err;

  epoch_result_t epoch_q[$];
  logic [7:0]    txt_bytes[$];

  int send_idle;
  int recv_stall;
  int mismatch_count;
  int results_seen;
  int stall_cycles;

  utc_timestamp_text_to_epoch dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .parse_ok      (parse_ok),
    .epoch_seconds (epoch_seconds)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // proleptic gregorian day number relative to 1970-01-01
  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_scan();
    scan_phase  = '0;
    scan_year   = '0;
    scan_month  = '0;
    scan_day    = '0;
    scan_hour   = '0;
    scan_minute = '0;
    scan_second = '0;
    scan_err    = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic last);
    logic          dig;
    logic [3:0]    dv;
    logic          sep_ok;
    epoch_result_t res;
    longint        secs;
    dig    = (c >= 8'h30) && (c <= 8'h39);
    dv     = c[3:0];
    sep_ok = 1'b0;
    if (!scan_err) begin
      if (scan_phase <= 5'd3) begin
        if (dig) scan_year = scan_year * 14'd10 + dv;
      end else if (scan_phase == 5'd5 || scan_phase == 5'd6) begin
        if (dig) scan_month = scan_month * 7'd10 + dv;
      end else if (scan_phase == 5'd8 || scan_phase == 5'd9) begin
        if (dig) scan_day = scan_day * 7'd10 + dv;
      end else if (scan_phase == 5'd11 || scan_phase == 5'd12) begin
        if (dig) scan_hour = scan_hour * 7'd10 + dv;
      end else if (scan_phase == 5'd14 || scan_phase == 5'd15) begin
        if (dig) scan_minute = scan_minute * 7'd10 + dv;
      end else if (scan_phase == 5'd17 || scan_phase == 5'd18) begin
        if (dig) scan_second = scan_second * 7'd10 + dv;
      end
      if (scan_phase <= 5'd3 || scan_phase == 5'd5 || scan_phase == 5'd6 ||
          scan_phase == 5'd8 || scan_phase == 5'd9 || scan_phase == 5'd11 ||
          scan_phase == 5'd12 || scan_phase == 5'd14 || scan_phase == 5'd15 ||
          scan_phase == 5'd17 || scan_phase == 5'd18) begin
        if (dig) scan_phase = scan_phase + 5'd1;
        else scan_err = 1'b1;
      end else if (scan_phase == PH_DASH1 || scan_phase == PH_DASH2 ||
                   scan_phase == PH_TEE || scan_phase == PH_COLON1 ||
                   scan_phase == PH_COLON2) begin
        if (scan_phase == PH_TEE) sep_ok = (c == CH_T_UP) || (c == CH_T_LO);
        else if (scan_phase == PH_COLON1 || scan_phase == PH_COLON2) sep_ok = (c == CH_COLON);
        else sep_ok = (c == CH_DASH);
        if (sep_ok) scan_phase = scan_phase + 5'd1;
        else scan_err = 1'b1;
      end else if (scan_phase == PH_AFTER_SEC) begin
        if (c == CH_DOT) scan_phase = PH_FRAC_ONE;
        else if (c == CH_Z_UP || c == CH_Z_LO) scan_phase = PH_DONE;
        else scan_err = 1'b1;
      end else if (scan_phase == PH_FRAC_ONE) begin
        if (dig) scan_phase = PH_FRAC_MORE;
        else scan_err = 1'b1;
      end else if (scan_phase == PH_FRAC_MORE) begin
        if (c == CH_Z_UP || c == CH_Z_LO) scan_phase = PH_DONE;
        else if (!dig) scan_err = 1'b1;
      end else begin
        // anything after the closing z
        scan_err = 1'b1;
      end
    end
    if (last) begin
      res.ok = !scan_err && scan_phase == PH_DONE &&
               scan_month >= 1 && scan_month <= 12 &&
               scan_day >= 1 && scan_day <= 31 &&
               scan_hour <= 23 && scan_minute <= 59 && scan_second <= 60;
      secs = 0;
      if (res.ok)
        secs = days_since_epoch(longint'(scan_year), longint'(scan_month),
                                longint'(scan_day)) * 86400 +
               longint'(scan_hour) * 3600 + longint'(scan_minute) * 60 +
               longint'(scan_second);
      res.secs = secs[38:0];
      epoch_q.push_back(res);
      clear_scan();
    end
  endtask

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk)
    if (!rst && in_valid && in_ready) predict_byte(text_byte, is_last);

  always @(posedge clk) begin : result_check
    epoch_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (epoch_q.size() == 0) begin
        report_error($sformatf("result with none expected: parse_ok=%0b epoch_seconds=%0d",
                               parse_ok, epoch_seconds));
      end else begin
        want = epoch_q.pop_front();
        if (parse_ok !== want.ok || epoch_seconds !== want.secs)
          report_error($sformatf("result %0d: expected ok=%0b secs=%0d, got ok=%0b secs=%0d",
                                 results_seen, want.ok, want.secs, parse_ok, epoch_seconds));
      end
      results_seen++;
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < txt_bytes.size(); i++)
      send_item(txt_bytes[i], i == txt_bytes.size() - 1);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) txt_bytes.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    txt_bytes.delete();
    append_text(s);
    send_buffer();
  endtask

  task automatic push_digits(input int v, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      txt_bytes.push_back(8'(8'h30 + (v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic make_random_text();
    int yr;
    int kind;
    int pos;
    txt_bytes.delete();
    case ($urandom_range(9))
      0: yr = 0;
      1: yr = 9999;
      2: yr = 1970;
      default: yr = $urandom_range(9999);
    endcase
    push_digits(yr, 4);
    txt_bytes.push_back(CH_DASH);
    push_digits(($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(99), 2);
    txt_bytes.push_back(CH_DASH);
    push_digits(($urandom_range(9) < 8) ? $urandom_range(1, 31) : $urandom_range(99), 2);
    txt_bytes.push_back($urandom_range(1) ? CH_T_UP : CH_T_LO);
    push_digits(($urandom_range(9) < 8) ? $urandom_range(23) : $urandom_range(99), 2);
    txt_bytes.push_back(CH_COLON);
    push_digits(($urandom_range(9) < 8) ? $urandom_range(59) : $urandom_range(99), 2);
    txt_bytes.push_back(CH_COLON);
    push_digits(($urandom_range(9) < 8) ? $urandom_range(60) : $urandom_range(99), 2);
    if ($urandom_range(1)) begin
      txt_bytes.push_back(CH_DOT);
      repeat ($urandom_range(1, 9)) txt_bytes.push_back(8'(8'h30 + $urandom_range(9)));
    end
    txt_bytes.push_back($urandom_range(1) ? CH_Z_UP : CH_Z_LO);
    kind = $urandom_range(99);
    if (kind < 60) begin
      // well formed, keep as is
    end else if (kind < 72) begin
      pos = $urandom_range(txt_bytes.size() - 1);
      txt_bytes[pos] = 8'($urandom_range(255));
    end else if (kind < 82) begin
      pos = $urandom_range(txt_bytes.size() - 2);
      while (txt_bytes.size() > pos + 1) void'(txt_bytes.pop_back());
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) txt_bytes.push_back(8'($urandom_range(255)));
    end else begin
      txt_bytes.delete();
      repeat ($urandom_range(1, 24)) txt_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_reference_dates();
    send_text("1970-01-01T00:00:00Z");
    send_text("0000-01-01T00:00:00Z");
    send_text("9999-12-31T23:59:60Z");
    send_text("2000-02-29T12:34:56Z");
    send_text("1969-12-31T23:59:59Z");
    send_text("0000-03-01T00:00:00Z");
  endtask

  task automatic test_field_limits();
    send_text("2024-00-10T00:00:00Z");
    send_text("2024-13-10T00:00:00Z");
    send_text("2024-12-00T00:00:00Z");
    send_text("2024-12-32T00:00:00Z");
    // day is not checked against month length
    send_text("2023-02-31T00:00:00Z");
    send_text("2024-06-15T24:00:00Z");
    send_text("2024-06-15T23:60:00Z");
    send_text("2024-06-15T23:59:61Z");
    send_text("9999-99-99T99:99:99Z");
  endtask

  task automatic test_case_and_fraction();
    send_text("2010-07-04t08:15:30z");
    send_text("2010-07-04T08:15:30.5Z");
    send_text("2010-07-04T08:15:30.0123456789z");
    send_text("2010-07-04T08:15:30.Z");
    send_text("2010-07-04T08:15:30.12.Z");
  endtask

  task automatic test_malformed();
    send_text("2010-07-04T08");
    send_text("Z");
    send_text("2010-07-04T08:15:30Zx");
    // error latched early, rest of text is ignored
    send_text("20x0-07-04T08:15:30Z");
    send_text("2010/07-04T08:15:30Z");
    send_text("2010-07-04 08:15:30Z");
    send_text("2010-07-04T08-15:30Z");
    send_text("2010-07-04T08:15:30+00:00");
    txt_bytes.delete();
    append_text("2021-06-15T12:30:");
    txt_bytes.push_back(8'h00);
    append_text("0Z");
    send_buffer();
    txt_bytes.delete();
    txt_bytes.push_back(8'h00);
    send_buffer();
    txt_bytes.delete();
    append_text("2021-06-15T12:30:00");
    txt_bytes.push_back(8'hFF);
    send_buffer();
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct, input int nbytes);
    int sent;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    sent = 0;
    while (sent < nbytes) begin
      make_random_text();
      send_buffer();
      sent += txt_bytes.size();
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    text_byte      = 8'h00;
    is_last        = 1'b0;
    out_ready      = 1'b0;
    send_idle      = 0;
    recv_stall     = 0;
    mismatch_count = 0;
    results_seen   = 0;
    stall_cycles   = 0;
    clear_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reference_dates();
    test_field_limits();
    test_case_and_fraction();
    test_malformed();
    test_random_stream(0, 0, 130);
    test_random_stream(61, 0, 130);
    test_random_stream(0, 61, 130);
    test_random_stream(15, 15, 130);

    in_valid <= 1'b0;
    while (epoch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && epoch_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
